// ----- sv/jfsp_pkg.sv -----
// Shared types and constants for the JPEG frame size parser.
`default_nettype none
package jfsp_pkg;

    // JPEG marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] CODE_SOF0   = 8'hC0;
    localparam logic [7:0] CODE_SOI    = 8'hD8;
    localparam logic [7:0] CODE_EOI    = 8'hD9;

    // Status codes
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    // Parser phase
    typedef enum logic [3:0] {
        PH_PREFIX     = 4'd0,
        PH_CODE       = 4'd1,
        PH_LEN_HI     = 4'd2,
        PH_LEN_LO     = 4'd3,
        PH_SKIP       = 4'd4,
        PH_SOF_LEN_HI = 4'd5,
        PH_SOF_LEN_LO = 4'd6,
        PH_PREC       = 4'd7,
        PH_H_HI       = 4'd8,
        PH_H_LO       = 4'd9,
        PH_W_HI       = 4'd10,
        PH_W_LO       = 4'd11
    } phase_t;

    // One result item, with its valid flag
    typedef struct packed {
        logic        vld;
        logic        status;
        logic [15:0] width;
        logic [15:0] height;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/jpeg_frame_size_parser_unit.sv -----
// Top level of the JPEG frame size parser: input register, parser, result buffer.
`default_nettype none
// Takes a JPEG frame one byte per item (last_byte set on the final byte) and
// walks its marker segments to the SOF0 header. It gives at most one result
// per frame: status 0 with the width and height, or status 1 with zeros when
// the frame has a bad marker, an EOI, a too-short segment length or ends before
// SOF0 is complete. Bytes after the result are dropped until the last byte,
// which rearms the parser. One item is accepted every cycle while in_stall is low;
// the byte is held in an input register, the parser updates its phase from it, and the
// result sits in an output register backed by a skid register, so out_valid
// rises once the result of an accepted byte is loaded into the output register. in_stall rises
// only when both result registers are full and an item waits in the input
// register.
module jpeg_frame_size_parser_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [15:0]      image_width,
    output logic [15:0]      image_height
);

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              q_ready;
    logic              step;
    jfsp_pkg::result_t result;

    assign step     = in_vld_reg && q_ready;
    assign in_stall = in_vld_reg && !q_ready;

    // Input register loads whenever its item moves on or it is empty
    always_comb
    begin
        in_vld_next = in_vld_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        if (!in_stall)
        begin
            in_vld_next = in_valid;
            byte_next   = data_byte;
            last_next   = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    jfsp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_reg),
        .last_in (last_reg),
        .result  (result)
    );

    jfsp_out_queue u_out_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (result),
        .ready        (q_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height)
    );

endmodule
`default_nettype wire

// ----- sv/jfsp_parser.sv -----
// Marker segment walker: phase state and per-byte update logic.
`default_nettype none
module jfsp_parser
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       byte_in,
    input  wire logic             last_in,
    output jfsp_pkg::result_t     result
);

    jfsp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  width_hi_reg, width_hi_next;
    logic        done_reg, done_next;

    logic        found;
    logic        fail;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;

    assign seg_len  = {len_hi_reg, byte_in};
    assign skip_dec = skip_reg - 16'd1;

    // Next state and result for the byte in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        len_hi_next   = len_hi_reg;
        height_next   = height_reg;
        width_hi_next = width_hi_reg;
        done_next     = done_reg;
        found         = 1'b0;
        fail          = 1'b0;
        result        = '0;

        if (step)
        begin
            if (done_reg)
            begin
                // ignore the rest of the frame
                if (last_in)
                begin
                    phase_next    = jfsp_pkg::PH_PREFIX;
                    skip_next     = '0;
                    len_hi_next   = '0;
                    height_next   = '0;
                    width_hi_next = '0;
                    done_next     = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    jfsp_pkg::PH_PREFIX:
                    begin
                        if (byte_in == jfsp_pkg::MARK_PREFIX)
                            phase_next = jfsp_pkg::PH_CODE;
                        else
                            fail = 1'b1;
                    end
                    jfsp_pkg::PH_CODE:
                    begin
                        if (byte_in < jfsp_pkg::CODE_SOF0 || byte_in == jfsp_pkg::CODE_EOI)
                            fail = 1'b1;
                        else if (byte_in == jfsp_pkg::CODE_SOI)
                            phase_next = jfsp_pkg::PH_PREFIX;
                        else if (byte_in == jfsp_pkg::CODE_SOF0)
                            phase_next = jfsp_pkg::PH_SOF_LEN_HI;
                        else
                            phase_next = jfsp_pkg::PH_LEN_HI;
                    end
                    jfsp_pkg::PH_LEN_HI:
                    begin
                        len_hi_next = byte_in;
                        phase_next  = jfsp_pkg::PH_LEN_LO;
                    end
                    jfsp_pkg::PH_LEN_LO:
                    begin
                        if (seg_len < 16'd2)
                            fail = 1'b1;
                        else if (seg_len == 16'd2)
                            phase_next = jfsp_pkg::PH_PREFIX;
                        else
                        begin
                            skip_next  = seg_len - 16'd2;
                            phase_next = jfsp_pkg::PH_SKIP;
                        end
                    end
                    jfsp_pkg::PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0)
                            phase_next = jfsp_pkg::PH_PREFIX;
                    end
                    jfsp_pkg::PH_SOF_LEN_HI: phase_next = jfsp_pkg::PH_SOF_LEN_LO;
                    jfsp_pkg::PH_SOF_LEN_LO: phase_next = jfsp_pkg::PH_PREC;
                    jfsp_pkg::PH_PREC:       phase_next = jfsp_pkg::PH_H_HI;
                    jfsp_pkg::PH_H_HI:
                    begin
                        height_next = {byte_in, 8'd0};
                        phase_next  = jfsp_pkg::PH_H_LO;
                    end
                    jfsp_pkg::PH_H_LO:
                    begin
                        height_next = {height_reg[15:8], byte_in};
                        phase_next  = jfsp_pkg::PH_W_HI;
                    end
                    jfsp_pkg::PH_W_HI:
                    begin
                        width_hi_next = byte_in;
                        phase_next    = jfsp_pkg::PH_W_LO;
                    end
                    jfsp_pkg::PH_W_LO:
                    begin
                        found = 1'b1;
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase

                // early end of frame
                if (!found && last_in)
                    fail = 1'b1;

                if (found)
                begin
                    result.vld    = 1'b1;
                    result.status = jfsp_pkg::STATUS_FOUND;
                    result.width  = {width_hi_reg, byte_in};
                    result.height = height_reg;
                end
                else if (fail)
                begin
                    result.vld    = 1'b1;
                    result.status = jfsp_pkg::STATUS_NOT_FOUND;
                end

                // one result per frame; rearm on the last byte
                if (found || fail)
                begin
                    if (last_in)
                    begin
                        phase_next    = jfsp_pkg::PH_PREFIX;
                        skip_next     = '0;
                        len_hi_next   = '0;
                        height_next   = '0;
                        width_hi_next = '0;
                        done_next     = 1'b0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= jfsp_pkg::PH_PREFIX;
            skip_reg     <= '0;
            len_hi_reg   <= '0;
            height_reg   <= '0;
            width_hi_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            len_hi_reg   <= len_hi_next;
            height_reg   <= height_next;
            width_hi_reg <= width_hi_next;
            done_reg     <= done_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/jfsp_out_queue.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module jfsp_out_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jfsp_pkg::result_t push,
    output logic                   ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   status,
    output logic [15:0]            image_width,
    output logic [15:0]            image_height
);

    jfsp_pkg::result_t head_reg, head_next;
    jfsp_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop   = head_reg.vld && !out_stall;
    assign ready = !(head_reg.vld && skid_reg.vld);

    // Move items between skid and head
    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        if (pop)
        begin
            if (skid_reg.vld)
            begin
                head_next = skid_reg;
                skid_next = push;
            end
            else
            begin
                head_next = push;
            end
        end
        else if (!head_reg.vld)
        begin
            head_next = push;
        end
        else if (push.vld)
        begin
            skid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            skid_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            skid_reg <= skid_next;
        end
    end

    assign out_valid    = head_reg.vld;
    assign status       = head_reg.status;
    assign image_width  = head_reg.width;
    assign image_height = head_reg.height;

endmodule
`default_nettype wire

// ----- dv/tb_jpeg_frame_size_parser_unit.sv -----
// Testbench for the JPEG frame size parser: directed and random frames checked by a scoreboard.

// One expected or observed result item
typedef struct packed {
    logic        status;
    logic [15:0] width;
    logic [15:0] height;
} frame_dims_t;

// Tracks the marker walk of the current frame and queues the dimensions it should report
class frame_dims_scoreboard;
    jfsp_pkg::phase_t walk_phase;
    logic [15:0]      bytes_to_skip;
    logic [7:0]       seg_len_msb;
    logic [15:0]      height_reg;
    logic [15:0]      width_reg;
    bit               answered;
    frame_dims_t      expected_dims[$];
    int               mismatch_count;
    int               dims_predicted;
    int               dims_found;
    int               dims_checked;

    function new();
        rearm();
        mismatch_count = 0;
        dims_predicted = 0;
        dims_found     = 0;
        dims_checked   = 0;
    endfunction

    function void rearm();
        walk_phase    = jfsp_pkg::PH_PREFIX;
        bytes_to_skip = '0;
        seg_len_msb   = '0;
        height_reg    = '0;
        width_reg     = '0;
        answered      = 1'b0;
    endfunction

    // Walk one accepted byte through the marker parser
    function void take_byte(logic [7:0] b, logic last);
        logic [15:0] seg_len;
        bit          found;
        bit          fail;
        frame_dims_t dims;
        found = 1'b0;
        fail  = 1'b0;

        // after a result, everything up to the last byte is dropped
        if (answered)
        begin
            if (last)
                rearm();
            return;
        end

        case (walk_phase)
            jfsp_pkg::PH_PREFIX:
            begin
                if (b == jfsp_pkg::MARK_PREFIX)
                    walk_phase = jfsp_pkg::PH_CODE;
                else
                    fail = 1'b1;
            end
            jfsp_pkg::PH_CODE:
            begin
                if (b < jfsp_pkg::CODE_SOF0 || b == jfsp_pkg::CODE_EOI)
                    fail = 1'b1;
                else if (b == jfsp_pkg::CODE_SOI)
                    walk_phase = jfsp_pkg::PH_PREFIX;
                else if (b == jfsp_pkg::CODE_SOF0)
                    walk_phase = jfsp_pkg::PH_SOF_LEN_HI;
                else
                    walk_phase = jfsp_pkg::PH_LEN_HI;
            end
            jfsp_pkg::PH_LEN_HI:
            begin
                seg_len_msb = b;
                walk_phase  = jfsp_pkg::PH_LEN_LO;
            end
            jfsp_pkg::PH_LEN_LO:
            begin
                seg_len = {seg_len_msb, b};
                if (seg_len < 16'd2)
                    fail = 1'b1;
                else if (seg_len == 16'd2)
                    walk_phase = jfsp_pkg::PH_PREFIX;
                else
                begin
                    bytes_to_skip = seg_len - 16'd2;
                    walk_phase    = jfsp_pkg::PH_SKIP;
                end
            end
            jfsp_pkg::PH_SKIP:
            begin
                bytes_to_skip = bytes_to_skip - 16'd1;
                if (bytes_to_skip == 16'd0)
                    walk_phase = jfsp_pkg::PH_PREFIX;
            end
            jfsp_pkg::PH_SOF_LEN_HI: walk_phase = jfsp_pkg::PH_SOF_LEN_LO;
            jfsp_pkg::PH_SOF_LEN_LO: walk_phase = jfsp_pkg::PH_PREC;
            jfsp_pkg::PH_PREC:       walk_phase = jfsp_pkg::PH_H_HI;
            jfsp_pkg::PH_H_HI:
            begin
                height_reg = {b, 8'h00};
                walk_phase = jfsp_pkg::PH_H_LO;
            end
            jfsp_pkg::PH_H_LO:
            begin
                height_reg[7:0] = b;
                walk_phase      = jfsp_pkg::PH_W_HI;
            end
            jfsp_pkg::PH_W_HI:
            begin
                width_reg  = {b, 8'h00};
                walk_phase = jfsp_pkg::PH_W_LO;
            end
            jfsp_pkg::PH_W_LO:
            begin
                width_reg[7:0] = b;
                found          = 1'b1;
            end
            default: fail = 1'b1;
        endcase

        // frame ended before the width was complete
        if (!found && last)
            fail = 1'b1;
        if (!found && !fail)
            return;

        if (found)
        begin
            dims.status = jfsp_pkg::STATUS_FOUND;
            dims.width  = width_reg;
            dims.height = height_reg;
            dims_found++;
        end
        else
        begin
            dims.status = jfsp_pkg::STATUS_NOT_FOUND;
            dims.width  = '0;
            dims.height = '0;
        end
        expected_dims = {expected_dims, dims};
        dims_predicted++;

        if (last)
            rearm();
        else
            answered = 1'b1;
    endfunction

    // Compare one result item with the oldest expectation
    function void check_dims(logic st, logic [15:0] w, logic [15:0] h);
        frame_dims_t want;
        if (expected_dims.size() == 0)
        begin
            $display("%0t: unexpected result: status=%0b width=%0d height=%0d",
                     $time, st, w, h);
            mismatch_count++;
            return;
        end
        want = expected_dims.pop_front();
        dims_checked++;
        if (st !== want.status)
        begin
            $display("%0t: status mismatch: expected %0b, actual %0b", $time, want.status, st);
            mismatch_count++;
        end
        if (w !== want.width)
        begin
            $display("%0t: width mismatch: expected %0d, actual %0d", $time, want.width, w);
            mismatch_count++;
        end
        if (h !== want.height)
        begin
            $display("%0t: height mismatch: expected %0d, actual %0d", $time, want.height, h);
            mismatch_count++;
        end
    endfunction
endclass

module tb_jpeg_frame_size_parser_unit;
    localparam int RANDOM_BYTES    = 510;
    localparam int HOLD_CYCLES     = 40;
    localparam int PRESSURE_FRAMES = 12;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [15:0] image_width;
    logic [15:0] image_height;

    frame_dims_scoreboard sb;
    logic [7:0] frame_q[$];
    int send_idle_pct       = 0;
    int stall_pct           = 0;
    bit hold_req            = 1'b0;
    int bytes_sent          = 0;
    int frames_sent         = 0;
    int quiet_cycles        = 0;
    int backpressure_cycles = 0;

    jpeg_frame_size_parser_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height)
    );

    always #6 clk = ~clk;

    // Receiver: random stalls, or one long hold-off on request
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                backpressure_cycles++;
            if (out_valid && !out_stall)
                sb.check_dims(status, image_width, image_height);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Append one byte to the frame being built
    function automatic void add_byte(input logic [7:0] b);
        frame_q = {frame_q, b};
    endfunction

    // Offer one byte, starting at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Segment codes that carry a length, fill code included
    function automatic logic [7:0] pick_segment_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(8'hC1, 8'hFF));
        while (code == jfsp_pkg::CODE_SOI || code == jfsp_pkg::CODE_EOI);
        return code;
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Mostly well-formed frames with random content; the rest broken or plain noise
    task automatic build_random_frame();
        int          kind;
        int          cut;
        logic [7:0]  code;
        logic [15:0] seg_len;
        logic [15:0] dim;
        frame_q.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
        end
        else
        begin
            if ($urandom_range(1) == 1)
            begin
                add_byte(jfsp_pkg::MARK_PREFIX);
                add_byte(jfsp_pkg::CODE_SOI);
            end
            // segments to skip, sometimes with an SOI in between
            repeat ($urandom_range(0, 2))
            begin
                code    = pick_segment_code();
                seg_len = 16'($urandom_range(2, 6));
                add_byte(jfsp_pkg::MARK_PREFIX);
                add_byte(code);
                add_byte(seg_len[15:8]);
                add_byte(seg_len[7:0]);
                repeat (seg_len - 2) add_byte(8'($urandom));
                if ($urandom_range(5) == 0)
                begin
                    add_byte(jfsp_pkg::MARK_PREFIX);
                    add_byte(jfsp_pkg::CODE_SOI);
                end
            end
            // the marker that settles the frame
            add_byte(jfsp_pkg::MARK_PREFIX);
            if (kind < 18)
                add_byte(8'($urandom_range(0, 8'hBF)));
            else if (kind < 26)
                add_byte(jfsp_pkg::CODE_EOI);
            else if (kind < 34)
            begin
                add_byte(pick_segment_code());
                add_byte(8'h00);
                add_byte(8'($urandom_range(1)));
            end
            else
            begin
                add_byte(jfsp_pkg::CODE_SOF0);
                repeat (3) add_byte(8'($urandom));
                dim = pick_dim();
                add_byte(dim[15:8]);
                add_byte(dim[7:0]);
                dim = pick_dim();
                add_byte(dim[15:8]);
                add_byte(dim[7:0]);
            end
            // cut some SOF0 frames short, pad the others with ignored bytes
            if (kind >= 34 && kind < 46)
            begin
                cut = $urandom_range(1, frame_q.size());
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
            else
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        end
    endtask

    initial
    begin
        int start_bytes;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames: bad prefix, bad code, EOI with trailing byte, SOI then SOF0
        // ending on the width, short length, fill code with length 2 then early end
        frame_q = {8'h00};
        send_frame();
        frame_q = {jfsp_pkg::MARK_PREFIX, 8'hBF};
        send_frame();
        frame_q = {jfsp_pkg::MARK_PREFIX, jfsp_pkg::CODE_EOI, 8'h12};
        send_frame();
        frame_q = {jfsp_pkg::MARK_PREFIX, jfsp_pkg::CODE_SOI, jfsp_pkg::MARK_PREFIX,
                   jfsp_pkg::CODE_SOF0, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame();
        frame_q = {jfsp_pkg::MARK_PREFIX, 8'hE0, 8'h00, 8'h01};
        send_frame();
        frame_q = {jfsp_pkg::MARK_PREFIX, jfsp_pkg::MARK_PREFIX, 8'h00, 8'h02,
                   jfsp_pkg::MARK_PREFIX};
        send_frame();

        // one-byte frames against a long output hold-off fill the block
        hold_req = 1'b1;
        repeat (PRESSURE_FRAMES)
        begin
            frame_q = {8'($urandom_range(0, 8'hFE))};
            send_frame();
        end

        // random frames over four idle/stall mixes
        start_bytes = bytes_sent;
        while ((bytes_sent - start_bytes) < RANDOM_BYTES)
        begin
            case ((bytes_sent - start_bytes) * 4 / RANDOM_BYTES)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
            endcase
            build_random_frame();
            send_frame();
        end
        in_valid <= 1'b0;

        // drain
        while (sb.expected_dims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d frames (%0d bytes) under four idle/stall mixes and one long hold-off;",
                 frames_sent, bytes_sent);
        $display("checked %0d results, %0d with dimensions; input stalled in %0d cycles.",
                 sb.dims_checked, sb.dims_found, backpressure_cycles);
        if (sb.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
